[rtl/hctl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hctl_pkg
// Shared types and constants for the Huffman total code length core.
// ----------------------------------------------------------------------------
package hctl_pkg;

  localparam int ALPHABET_SIZE_DEF = 256;
  localparam int COUNT_WIDTH_DEF   = 16;
  localparam int TOTAL_WIDTH       = 24;

  localparam logic [7:0]             NEWLINE_CODE = 8'd10;
  localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX    = {TOTAL_WIDTH{1'b1}};

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_WIDTH-1:0] total_bits;
    logic                   overflow;
  } out_item_t;

  // Classified beat handed from front to back.
  typedef struct packed {
    logic [7:0] symbol;
    logic       count;
    logic       last;
  } q_item_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_COUNT,
    B_GATHER,
    B_SCAN,
    B_MERGE,
    B_MOVE,
    B_EMIT
  } back_state_t;

endpackage
`default_nettype wire

[rtl/huffman_total_code_length_core.sv]
`default_nettype none
// A counted byte is read in IDLE and written back in COUNT before the next
// is popped; the 2-beat queue ahead stalls input when it is full. The last
// byte adds a sweep over all ALPHABET_SIZE counts, then for each merge a scan
// of the n live weights, a merge and at need a move, then the output register.
// Reset: the count memory is cleared by a pass over all ALPHABET_SIZE entries,
// during which no byte is taken.
// ----------------------------------------------------------------------------
// huffman_total_code_length_core
// Counts byte frequencies per data set and reports the Huffman weighted path
// length when the last byte arrives.
// ----------------------------------------------------------------------------
module huffman_total_code_length_core #(
  parameter int ALPHABET_SIZE = hctl_pkg::ALPHABET_SIZE_DEF,
  parameter int COUNT_WIDTH   = hctl_pkg::COUNT_WIDTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  hctl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output hctl_pkg::out_item_t out_data
);

  hctl_pkg::q_item_t   q_data;
  hctl_pkg::out_item_t res_data;
  logic q_valid;
  logic q_pop;
  logic clearing;
  logic res_valid;
  logic res_take;

  // Front: classify each beat and hold those that count or close a set in a short queue.
  hctl_front #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .hold     (clearing),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  // Back: count, then merge weights on the last beat of a set.
  hctl_back #(
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_take  (res_take)
  );

  // Output register: load when empty or when the held beat is taken.
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_data <= res_data;
    end
  end

endmodule
`default_nettype wire

[rtl/hctl_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hctl_front
// Accepts input beats, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module hctl_front #(
  parameter int ALPHABET_SIZE = hctl_pkg::ALPHABET_SIZE_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  hctl_pkg::in_item_t  in_data,
  input  wire                 hold,
  output logic                q_valid,
  output hctl_pkg::q_item_t   q_data,
  input  wire                 q_pop
);

  hctl_pkg::q_item_t ent [2];
  logic [1:0] cnt;
  logic       wp;
  logic       rp;
  logic       countable;
  logic       push;
  logic       pop;

  // Newlines and symbols outside the alphabet are not counted.
  assign countable = (in_data.symbol != hctl_pkg::NEWLINE_CODE) &&
                     ({1'b0, in_data.symbol} < 9'(ALPHABET_SIZE));
  assign in_stall  = (cnt == 2'd2) || hold;
  // Drop beats that neither count nor close a set.
  assign push      = in_valid && !in_stall && (countable || in_data.last);
  assign q_valid   = (cnt != 2'd0);
  assign pop       = q_pop && q_valid;
  assign q_data    = ent[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= '{symbol: in_data.symbol, count: countable, last: in_data.last};
    end
  end

endmodule
`default_nettype wire

[rtl/hctl_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hctl_back
// Counts symbols, then gathers weights and merges the two smallest in turn.
// ----------------------------------------------------------------------------
module hctl_back #(
  parameter int ALPHABET_SIZE = hctl_pkg::ALPHABET_SIZE_DEF,
  parameter int COUNT_WIDTH   = hctl_pkg::COUNT_WIDTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 q_valid,
  input  hctl_pkg::q_item_t   q_data,
  output logic                q_pop,
  output logic                clearing,
  output logic                res_valid,
  output hctl_pkg::out_item_t res_data,
  input  wire                 res_take
);

  localparam int AW  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int NW  = AW + 1;
  localparam int WW  = COUNT_WIDTH + AW;
  localparam int TW  = hctl_pkg::TOTAL_WIDTH;
  localparam int CSW = ((WW > TW) ? WW : TW) + 1;

  localparam logic [NW-1:0]          A_N      = NW'(ALPHABET_SIZE);
  localparam logic [NW-1:0]          LAST_IDX = NW'(ALPHABET_SIZE - 1);
  localparam logic [NW-1:0]          ONE_N    = NW'(1);
  localparam logic [COUNT_WIDTH-1:0] CMAX     = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] freq [ALPHABET_SIZE];
  logic [WW-1:0]          wmem [ALPHABET_SIZE];
  logic [COUNT_WIDTH-1:0] frd;
  logic [WW-1:0]          wrd;

  logic                   fwe, wwe;
  logic [AW-1:0]          fwa, fra, wwa, wra;
  logic [COUNT_WIDTH-1:0] fwd;
  logic [WW-1:0]          wwd;

  hctl_pkg::back_state_t state, state_next;
  logic [NW-1:0] idx, idx_next, n, n_next;
  logic          rv, rv_next;
  logic [AW-1:0] ridx, ridx_next, sym, sym_next;
  logic          lst, lst_next;
  logic [WW-1:0] a, a_next, b, b_next;
  logic [AW-1:0] i1, i1_next, i2, i2_next;
  logic          h1, h1_next, h2, h2_next;
  logic [TW-1:0] cost, cost_next;
  logic          csat, csat_next, sat, sat_next;

  logic [WW-1:0]  sum;
  logic [NW-1:0]  last_n;
  logic [CSW-1:0] cost_sum;
  logic           merged;
  logic           start_gather;

  always_ff @(posedge clk) begin
    if (fwe) begin
      freq[fwa] <= fwd;
    end
    frd <= freq[fra];
  end

  always_ff @(posedge clk) begin
    if (wwe) begin
      wmem[wwa] <= wwd;
    end
    wrd <= wmem[wra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hctl_pkg::B_CLEAR;
      idx   <= '0;
      rv    <= 1'b0;
      n     <= '0;
      h1    <= 1'b0;
      h2    <= 1'b0;
      cost  <= '0;
      csat  <= 1'b0;
      sat   <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      rv    <= rv_next;
      n     <= n_next;
      h1    <= h1_next;
      h2    <= h2_next;
      cost  <= cost_next;
      csat  <= csat_next;
      sat   <= sat_next;
    end
  end

  always_ff @(posedge clk) begin
    ridx <= ridx_next;
    sym  <= sym_next;
    lst  <= lst_next;
    a    <= a_next;
    b    <= b_next;
    i1   <= i1_next;
    i2   <= i2_next;
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    rv_next    = rv;
    n_next     = n;
    ridx_next  = ridx;
    sym_next   = sym;
    lst_next   = lst;
    a_next     = a;
    b_next     = b;
    i1_next    = i1;
    i2_next    = i2;
    h1_next    = h1;
    h2_next    = h2;
    cost_next  = cost;
    csat_next  = csat;
    sat_next   = sat;
    fwe        = 1'b0;
    fwa        = idx[AW-1:0];
    fwd        = '0;
    fra        = q_data.symbol[AW-1:0];
    wwe        = 1'b0;
    wwa        = n[AW-1:0];
    wwd        = '0;
    wra        = idx[AW-1:0];
    q_pop      = 1'b0;
    res_valid  = 1'b0;
    merged     = 1'b0;
    start_gather = 1'b0;
    sum        = a + b;
    last_n     = n - ONE_N;
    cost_sum   = CSW'(cost) + CSW'(sum);

    case (state)
      hctl_pkg::B_CLEAR: begin
        fwe = 1'b1;
        if (idx == LAST_IDX) begin
          idx_next   = '0;
          state_next = hctl_pkg::B_IDLE;
        end else begin
          idx_next = idx + ONE_N;
        end
      end
      hctl_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          sym_next = q_data.symbol[AW-1:0];
          lst_next = q_data.last;
          if (q_data.count) begin
            state_next = hctl_pkg::B_COUNT;
          end else begin
            start_gather = 1'b1;
          end
        end
      end
      hctl_pkg::B_COUNT: begin
        // Saturate the count and flag it.
        if (frd == CMAX) begin
          sat_next = 1'b1;
        end else begin
          fwe = 1'b1;
          fwa = sym;
          fwd = frd + 1'b1;
        end
        if (lst) begin
          start_gather = 1'b1;
        end else begin
          state_next = hctl_pkg::B_IDLE;
        end
      end
      hctl_pkg::B_GATHER: begin
        // Sweep the counts: pack nonzero ones into the weight list, clear all.
        fra = idx[AW-1:0];
        if (idx != A_N) begin
          idx_next  = idx + ONE_N;
          rv_next   = 1'b1;
          ridx_next = idx[AW-1:0];
        end else begin
          rv_next = 1'b0;
        end
        if (rv) begin
          fwe = 1'b1;
          fwa = ridx;
          if (frd != '0) begin
            wwe    = 1'b1;
            wwa    = n[AW-1:0];
            wwd    = WW'(frd);
            n_next = n + ONE_N;
          end
        end
        if ((idx == A_N) && !rv) begin
          if (n > ONE_N) begin
            idx_next   = '0;
            h1_next    = 1'b0;
            h2_next    = 1'b0;
            state_next = hctl_pkg::B_SCAN;
          end else begin
            state_next = hctl_pkg::B_EMIT;
          end
        end
      end
      hctl_pkg::B_SCAN: begin
        // One pass finds the two smallest weights.
        wra = idx[AW-1:0];
        if (idx != n) begin
          idx_next  = idx + ONE_N;
          rv_next   = 1'b1;
          ridx_next = idx[AW-1:0];
        end else begin
          rv_next = 1'b0;
        end
        if (rv) begin
          if (!h1) begin
            a_next  = wrd;
            i1_next = ridx;
            h1_next = 1'b1;
          end else if (wrd < a) begin
            b_next  = a;
            i2_next = i1;
            h2_next = 1'b1;
            a_next  = wrd;
            i1_next = ridx;
          end else if (!h2 || (wrd < b)) begin
            b_next  = wrd;
            i2_next = ridx;
            h2_next = 1'b1;
          end
        end
        if ((idx == n) && !rv) begin
          state_next = hctl_pkg::B_MERGE;
        end
      end
      hctl_pkg::B_MERGE: begin
        if (cost_sum > CSW'(hctl_pkg::TOTAL_MAX)) begin
          cost_next = hctl_pkg::TOTAL_MAX;
          csat_next = 1'b1;
        end else begin
          cost_next = cost_sum[TW-1:0];
        end
        wwe = 1'b1;
        wwd = sum;
        // Place the sum and drop the tail entry into the freed slot.
        if (last_n[AW-1:0] == i2) begin
          wwa    = i1;
          merged = 1'b1;
        end else if (last_n[AW-1:0] == i1) begin
          wwa    = i2;
          merged = 1'b1;
        end else begin
          wwa        = i2;
          wra        = last_n[AW-1:0];
          state_next = hctl_pkg::B_MOVE;
        end
      end
      hctl_pkg::B_MOVE: begin
        wwe    = 1'b1;
        wwa    = i1;
        wwd    = wrd;
        merged = 1'b1;
      end
      hctl_pkg::B_EMIT: begin
        res_valid = 1'b1;
        if (res_take) begin
          cost_next  = '0;
          csat_next  = 1'b0;
          sat_next   = 1'b0;
          state_next = hctl_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = hctl_pkg::B_IDLE;
      end
    endcase

    if (start_gather) begin
      idx_next   = '0;
      rv_next    = 1'b0;
      n_next     = '0;
      state_next = hctl_pkg::B_GATHER;
    end

    if (merged) begin
      n_next = last_n;
      if (last_n > ONE_N) begin
        idx_next   = '0;
        rv_next    = 1'b0;
        h1_next    = 1'b0;
        h2_next    = 1'b0;
        state_next = hctl_pkg::B_SCAN;
      end else begin
        state_next = hctl_pkg::B_EMIT;
      end
    end
  end

  assign clearing            = (state == hctl_pkg::B_CLEAR);
  assign res_data.total_bits = cost;
  assign res_data.overflow   = sat | csat;

endmodule
`default_nettype wire

[verif/huffman_total_code_length_core_tb.sv]
// ----------------------------------------------------------------------------
// Huffman total code length core testbench
// Sends byte streams split into data sets and checks each reported weighted
// path length and overflow flag against a behavioural predictor. Both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module huffman_total_code_length_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hctl_pkg::*;

  localparam int          ALPHA      = ALPHABET_SIZE_DEF;
  localparam longint      COUNT_MAX  = (64'd1 << COUNT_WIDTH_DEF) - 1;
  localparam longint      CYCLE_STOP = 3000000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Predictor state: per-set byte counts and the saturation mark.
  longint    byte_count [ALPHA];
  bit        count_saturated;
  out_item_t pending_totals [$];

  int        errors;
  int        beats_sent;
  int        sets_sent;
  int        results_seen;
  longint    cycles;
  int        gap_pct;        // chance of an idle gap before a beat
  int        stall_pct;      // chance of the receiver stalling
  int        stall_hold;

  huffman_total_code_length_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: no correct run comes near this many cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_STOP) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("FAIL huffman_total_code_length_core");
      $finish;
    end
  end

  // Receiver back-pressure: hold each stall decision for a run of cycles,
  // mostly short runs with the odd long one.
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 99) < stall_pct);
      stall_hold <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 3);
    end
  end

  // Weighted path length of the current counts: merge the two smallest
  // weights until one is left, summing each merged weight.
  function automatic out_item_t huffman_cost();
    longint    weights [$];
    longint    a;
    longint    b;
    longint    cost;
    int        k;
    out_item_t res;
    cost = 0;
    for (int s = 0; s < ALPHA; s++) begin
      if (byte_count[s] != 0) weights.push_back(byte_count[s]);
    end
    while (weights.size() > 1) begin
      k = 0;
      for (int i = 1; i < weights.size(); i++) if (weights[i] < weights[k]) k = i;
      a = weights[k];
      weights.delete(k);
      k = 0;
      for (int i = 1; i < weights.size(); i++) if (weights[i] < weights[k]) k = i;
      b = weights[k];
      weights[k] = a + b;
      cost += a + b;
    end
    res.overflow = count_saturated;
    if (cost > longint'(TOTAL_MAX)) begin
      cost = TOTAL_MAX;
      res.overflow = 1'b1;
    end
    res.total_bits = cost[TOTAL_WIDTH-1:0];
    return res;
  endfunction

  // Fold one accepted beat into the predictor; on last, queue the total.
  task automatic account_beat(input logic [7:0] sym, input logic fin);
    if (sym != NEWLINE_CODE && int'(sym) < ALPHA) begin
      if (byte_count[sym] >= COUNT_MAX) count_saturated = 1'b1;
      else byte_count[sym]++;
    end
    if (fin) begin
      pending_totals.push_back(huffman_cost());
      foreach (byte_count[s]) byte_count[s] = 0;
      count_saturated = 1'b0;
      sets_sent++;
    end
  endtask

  // Drive one beat; valid is lowered only when an idle gap goes in front,
  // so back-to-back beats keep it high.
  task automatic send_byte(input logic [7:0] sym, input logic fin);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < gap_pct)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data.symbol <= sym;
    in_data.last   <= fin;
    do @(posedge clk); while (in_stall);
    account_beat(sym, fin);
    beats_sent++;
  endtask

  // Check each result beat against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_totals.size() == 0) begin
        $display("%0t: unexpected result total_bits=%0d overflow=%0b",
                 $time, out_data.total_bits, out_data.overflow);
        errors++;
      end else begin
        want = pending_totals.pop_front();
        if (out_data.total_bits !== want.total_bits) begin
          $display("%0t: total_bits expected %0d actual %0d",
                   $time, want.total_bits, out_data.total_bits);
          errors++;
        end
        if (out_data.overflow !== want.overflow) begin
          $display("%0t: overflow expected %0b actual %0b",
                   $time, want.overflow, out_data.overflow);
          errors++;
        end
      end
    end
  end

  // Edge cases: empty set, lone newline, single symbol, the field extremes,
  // ties between equal weights.
  task automatic test_directed();
    send_byte(8'd10, 1'b1);                    // empty set
    send_byte(8'd0, 1'b1);                     // one symbol, one byte
    send_byte(8'd255, 1'b0);
    send_byte(8'd255, 1'b0);
    send_byte(8'd10, 1'b1);                    // newline on the last beat
    send_byte(8'd0, 1'b0);
    send_byte(8'd255, 1'b1);                   // two symbols
    for (int i = 0; i < 4; i++) send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'd10, 1'b0);
    send_byte(8'h01, 1'b1);
    for (int i = 0; i < 6; i++) send_byte(8'(i * 37 + 1), i == 5);   // equal weights
  endtask

  // Every byte value in one set: the widest merge the core does.
  task automatic test_full_alphabet();
    for (int s = 0; s < ALPHA; s++) send_byte(8'(s), 1'b0);
    for (int s = 0; s < 40; s++) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'd128, 1'b1);
  endtask

  // Random data sets: mostly small symbol pools and short sets, some wide
  // pools and long sets, newlines sprinkled in.
  task automatic test_random_sets(input int target);
    int       len;
    int       base;
    int       span;
    logic [7:0] sym;
    while (beats_sent < target) begin
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      base = $urandom_range(0, 255);
      span = ($urandom_range(0, 5) == 0) ? 256 : $urandom_range(1, 8);
      gap_pct   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 60);
      stall_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 70);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 15) == 0) sym = NEWLINE_CODE;
        else sym = 8'((base + $urandom_range(0, span - 1)) % 256);
        send_byte(sym, i == len - 1);
      end
    end
  endtask

  initial begin
    errors       = 0;
    beats_sent   = 0;
    sets_sent    = 0;
    results_seen = 0;
    cycles       = 0;
    stall_hold   = 0;
    gap_pct      = 30;
    stall_pct    = 30;
    count_saturated = 1'b0;
    foreach (byte_count[s]) byte_count[s] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_full_alphabet();
    test_random_sets(1400);
    in_valid <= 1'b0;

    // Drain: wait for every outstanding total, then settle a little.
    while (pending_totals.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d beats in %0d data sets, %0d totals checked, %0d cycles.",
             beats_sent, sets_sent, results_seen, cycles);
    $display("Included empty, single-symbol, full-alphabet and random sets.");
    if (errors == 0) begin
      $display("PASS huffman_total_code_length_core");
    end else begin
      $display("FAIL huffman_total_code_length_core");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/hctl_pkg.sv
rtl/hctl_front.sv
rtl/hctl_back.sv
rtl/huffman_total_code_length_core.sv
verif/huffman_total_code_length_core_tb.sv
